// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition is followed in the next cycle by another.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/pts_pkg.sv -----
// Shared types and codes for the process table scheduler.
// No dependencies; imported by the scan, accounting and top scheduler modules.
`timescale 1ns / 1ps
package pts_pkg;

  // Slot life states
  localparam logic [2:0] ST_FREE  = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_BLOCK = 3'd3;
  localparam logic [2:0] ST_DEAD  = 3'd4;

  // Operation codes
  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_ADMIT = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BLOCKED = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_NOFREE  = 2'd3;

  // One slot table entry as held in the table RAM
  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] last_clock;
    logic [31:0] ready_total;
    logic [31:0] ready_visits;
    logic [31:0] blocked_total;
    logic [31:0] run_total;
    logic [31:0] last_run;
    logic [31:0] change_count;
  } pts_entry_t;

  // Scan control from the sequencer
  typedef struct packed {
    logic clear;
    logic step;
  } pts_scan_ctl_t;

  // Scan summary back to the sequencer
  typedef struct packed {
    logic any_ready;
    logic any_free;
    logic any_blocked;
  } pts_scan_sts_t;

endpackage

// ----- rtl/pts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pts_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pts_scan.sv -----
// Table scan accumulator: one entry per step, tracks the ready and free picks
// and whether any slot is blocked. Depends on pts_pkg.
`timescale 1ns / 1ps
module pts_scan #(
  parameter int IW = 4
) (
  input  logic                   clk,
  input  pts_pkg::pts_scan_ctl_t ctl,
  input  logic [IW-1:0]          idx,
  input  logic [2:0]             st,
  input  logic [31:0]            last_run,
  input  logic [IW-1:0]          cur,
  input  logic                   policy,
  output logic [IW-1:0]          ready_pick,
  output logic [IW-1:0]          free_pick,
  output pts_pkg::pts_scan_sts_t sts
);
  import pts_pkg::*;

  logic          lo_found_r, lo_found_nxt;
  logic [IW-1:0] lo_idx_r, lo_idx_nxt;
  logic          hi_found_r, hi_found_nxt;
  logic [IW-1:0] hi_idx_r, hi_idx_nxt;
  logic [IW-1:0] min_idx_r, min_idx_nxt;
  logic [31:0]   min_val_r, min_val_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          blk_r, blk_nxt;

  // Fold one entry into the running picks
  always_comb begin
    lo_found_nxt   = lo_found_r;
    lo_idx_nxt     = lo_idx_r;
    hi_found_nxt   = hi_found_r;
    hi_idx_nxt     = hi_idx_r;
    min_idx_nxt    = min_idx_r;
    min_val_nxt    = min_val_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    blk_nxt        = blk_r;
    if (ctl.clear) begin
      lo_found_nxt   = 1'b0;
      hi_found_nxt   = 1'b0;
      free_found_nxt = 1'b0;
      blk_nxt        = 1'b0;
    end else if (ctl.step) begin
      if (st == ST_READY) begin
        if (!lo_found_r) begin
          lo_found_nxt = 1'b1;
          lo_idx_nxt   = idx;
          min_idx_nxt  = idx;
          min_val_nxt  = last_run;
        end else if (last_run < min_val_r) begin
          min_idx_nxt = idx;
          min_val_nxt = last_run;
        end
        // first ready slot after the current one
        if (!hi_found_r && idx > cur) begin
          hi_found_nxt = 1'b1;
          hi_idx_nxt   = idx;
        end
      end
      if (st == ST_FREE && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx;
      end
      if (st == ST_BLOCK) begin
        blk_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_found_r   <= lo_found_nxt;
    lo_idx_r     <= lo_idx_nxt;
    hi_found_r   <= hi_found_nxt;
    hi_idx_r     <= hi_idx_nxt;
    min_idx_r    <= min_idx_nxt;
    min_val_r    <= min_val_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    blk_r        <= blk_nxt;
  end

  // Round robin wraps to the lowest ready slot when none follows current
  assign ready_pick      = policy ? min_idx_r : (hi_found_r ? hi_idx_r : lo_idx_r);
  assign free_pick       = free_idx_r;
  assign sts.any_ready   = lo_found_r;
  assign sts.any_free    = free_found_r;
  assign sts.any_blocked = blk_r;

endmodule

// ----- rtl/pts_acct.sv -----
// Time accounting for one slot state change.
// Depends on pts_pkg.
`timescale 1ns / 1ps
module pts_acct (
  input  pts_pkg::pts_entry_t ent,
  input  logic [31:0]         elapsed,
  input  logic [2:0]          new_state,
  input  logic [31:0]         now,
  output pts_pkg::pts_entry_t upd
);
  import pts_pkg::*;

  logic pos;

  assign pos = (elapsed != 32'd0) && !elapsed[31];

  // Store new state, stamp time, charge positive elapsed time to the old state
  always_comb begin
    upd              = ent;
    upd.st           = new_state;
    upd.last_clock   = now;
    upd.change_count = ent.change_count + 32'd1;
    if (pos) begin
      unique case (ent.st)
        ST_READY: begin
          upd.ready_visits = ent.ready_visits + 32'd1;
          upd.ready_total  = ent.ready_total + elapsed;
        end
        ST_BLOCK: begin
          upd.blocked_total = ent.blocked_total + elapsed;
        end
        ST_RUN: begin
          upd.last_run  = elapsed;
          upd.run_total = ent.run_total + elapsed;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/process_table_scheduler.sv -----
// Process table scheduler: a state change reads the slot and writes it back;
// admit and schedule scan the table (one table RAM read a cycle), then pick, and
// a scheduled slot is read and written back. Invalid slots and unknown ops
// answer at once. One item at a time: busy stays high until the result strobe
// is issued. Synchronous active-low reset clears the per-slot valid bits, so
// the table reads as all free and zero at once; results cannot be stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module process_table_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_slot,
  input  logic [2:0]  in_new_state,
  input  logic [31:0] in_now,
  output logic        out_valid,
  output logic [3:0]  out_chosen_slot,
  output logic [1:0]  out_status,
  output logic [31:0] out_ready_time,
  output logic [31:0] out_ready_count,
  output logic [31:0] out_blocked_time,
  output logic [31:0] out_run_time,
  output logic [31:0] out_transitions,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_wdata
);
  import pts_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int EW = $bits(pts_entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic             policy_r;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [SLOTS-1:0] valid_r;
  logic [1:0]       op_r, op_nxt;
  logic [2:0]       tgt_ns_r, tgt_ns_nxt;
  logic [IW-1:0]    tgt_idx_r, tgt_idx_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    rd_idx_r;
  pts_entry_t       ent_r, ent_nxt;
  logic [31:0]      elapsed_r, elapsed_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       chosen_r, chosen_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             show_r, show_nxt;
  pts_entry_t       shown_r, shown_nxt;

  logic             accept;
  logic             slot_bad;
  logic [IW+3:0]    slot_wide;
  logic [IW-1:0]    slot_idx;
  logic [IW-1:0]    raddr;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  pts_entry_t       ram_wdata;
  logic [EW-1:0]    ram_rdata;
  pts_entry_t       rd_ent;
  pts_entry_t       upd;
  pts_scan_ctl_t    scan_ctl;
  pts_scan_sts_t    scan_sts;
  logic [IW-1:0]    ready_pick;
  logic [IW-1:0]    free_pick;
  logic [IW+3:0]    pick_wide;
  logic [IW+3:0]    cur_wide;
  logic [IW+3:0]    free_wide;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign slot_wide = {{IW{1'b0}}, in_slot};
  assign slot_idx  = slot_wide[IW-1:0];
  assign slot_bad  = slot_wide >= (IW+4)'(SLOTS);
  assign pick_wide = {4'b0, tgt_idx_r};
  assign cur_wide  = {4'b0, cur_r};
  assign free_wide = {4'b0, free_pick};

  // Entries never written since reset read as free and zero
  assign rd_ent = valid_r[rd_idx_r] ? pts_entry_t'(ram_rdata) : pts_entry_t'('0);

  pts_ram #(
    .W (EW),
    .D (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  pts_scan #(
    .IW (IW)
  ) u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .idx        (cnt_r),
    .st         (rd_ent.st),
    .last_run   (rd_ent.last_run),
    .cur        (cur_r),
    .policy     (policy_r),
    .ready_pick (ready_pick),
    .free_pick  (free_pick),
    .sts        (scan_sts)
  );

  pts_acct u_acct (
    .ent       (ent_r),
    .elapsed   (elapsed_r),
    .new_state (tgt_ns_r),
    .now       (now_r),
    .upd       (upd)
  );

  // Sequencer: scan, pick, read, write back, issue result
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    op_nxt         = op_r;
    tgt_ns_nxt     = tgt_ns_r;
    tgt_idx_nxt    = tgt_idx_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    ent_nxt        = ent_r;
    elapsed_nxt    = elapsed_r;
    raddr          = rd_idx_r;
    ram_we         = 1'b0;
    ram_waddr      = tgt_idx_r;
    ram_wdata      = upd;
    scan_ctl.clear = 1'b0;
    scan_ctl.step  = 1'b0;
    out_valid_nxt  = 1'b0;
    chosen_nxt     = chosen_r;
    status_nxt     = status_r;
    show_nxt       = show_r;
    shown_nxt      = shown_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_op;
          tgt_ns_nxt  = in_new_state;
          tgt_idx_nxt = slot_idx;
          now_nxt     = in_now;
          cnt_nxt     = '0;
          if (in_op == OP_MOVE && !slot_bad) begin
            raddr     = slot_idx;
            state_nxt = S_RD;
          end else if (in_op == OP_SCHED || in_op == OP_ADMIT) begin
            raddr          = '0;
            scan_ctl.clear = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            // out-of-table slot or unknown op: answer at once
            out_valid_nxt = 1'b1;
            chosen_nxt    = (in_op == OP_MOVE) ? in_slot : cur_wide[3:0];
            status_nxt    = STAT_OK;
            show_nxt      = 1'b0;
          end
        end
      end
      S_SCAN: begin
        scan_ctl.step = 1'b1;
        if (cnt_r == IW'(SLOTS - 1)) begin
          state_nxt = S_PICK;
        end else begin
          raddr   = cnt_r + IW'(1);
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      S_PICK: begin
        if (op_r == OP_SCHED) begin
          if (scan_sts.any_ready) begin
            tgt_idx_nxt = ready_pick;
            tgt_ns_nxt  = ST_RUN;
            raddr       = ready_pick;
            state_nxt   = S_RD;
          end else begin
            out_valid_nxt = 1'b1;
            chosen_nxt    = cur_wide[3:0];
            status_nxt    = scan_sts.any_blocked ? STAT_BLOCKED : STAT_EMPTY;
            show_nxt      = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          out_valid_nxt = 1'b1;
          show_nxt      = 1'b0;
          state_nxt     = S_IDLE;
          if (scan_sts.any_free) begin
            // admitted slot comes up ready with every counter cleared
            ram_we       = 1'b1;
            ram_waddr    = free_pick;
            ram_wdata    = '0;
            ram_wdata.st = ST_READY;
            chosen_nxt   = free_wide[3:0];
            status_nxt   = STAT_OK;
          end else begin
            chosen_nxt = 4'd0;
            status_nxt = STAT_NOFREE;
          end
        end
      end
      S_RD: begin
        ent_nxt     = rd_ent;
        elapsed_nxt = now_r - rd_ent.last_clock;
        state_nxt   = S_WB;
      end
      S_WB: begin
        out_valid_nxt = 1'b1;
        chosen_nxt    = pick_wide[3:0];
        status_nxt    = STAT_OK;
        show_nxt      = 1'b1;
        state_nxt     = S_IDLE;
        if (tgt_ns_r <= ST_DEAD) begin
          ram_we    = 1'b1;
          shown_nxt = upd;
        end else begin
          shown_nxt = ent_r;
        end
        if (op_r == OP_SCHED) begin
          cur_nxt = tgt_idx_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      cur_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata[0];
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    tgt_ns_r  <= tgt_ns_nxt;
    tgt_idx_r <= tgt_idx_nxt;
    now_r     <= now_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= raddr;
    ent_r     <= ent_nxt;
    elapsed_r <= elapsed_nxt;
    chosen_r  <= chosen_nxt;
    status_r  <= status_nxt;
    show_r    <= show_nxt;
    shown_r   <= shown_nxt;
  end

  // Result ports: counters read zero unless a slot is shown
  assign out_valid        = out_valid_r;
  assign out_chosen_slot  = chosen_r;
  assign out_status       = status_r;
  assign out_ready_time   = show_r ? shown_r.ready_total   : 32'd0;
  assign out_ready_count  = show_r ? shown_r.ready_visits  : 32'd0;
  assign out_blocked_time = show_r ? shown_r.blocked_total : 32'd0;
  assign out_run_time     = show_r ? shown_r.run_total     : 32'd0;
  assign out_transitions  = show_r ? shown_r.change_count  : 32'd0;

  `ASSERT_CLK(a_we_phase, clk, rst_n, !ram_we || state_r == S_PICK || state_r == S_WB)
  `ASSERT_NEXT(a_rd_then_wb, clk, rst_n, state_r == S_RD, state_r == S_WB)
  `ASSERT_NEXT(a_wb_result, clk, rst_n, state_r == S_WB, out_valid_r && show_r)
  `ASSERT_NEXT(a_scan_step, clk, rst_n, state_r == S_SCAN && cnt_r != IW'(SLOTS - 1), state_r == S_SCAN && cnt_r == $past(cnt_r) + IW'(1))

endmodule
